FILE: rtl/pms_pkg.sv
// Package with shared constants, types and tables of the melody sequencer.
`timescale 1ns / 1ps

package pms_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int MELODY_COUNT    = 14;
    localparam int TIMER_CLOCK_HZ  = 2000000;
    localparam int DUTY_SCALE      = 200;

    localparam int MEL_W     = 4;
    localparam int PERIOD_W  = 21;
    localparam int COMPARE_W = 18;
    localparam int PEND_W    = 3;
    localparam int MS_W      = 16;
    localparam int FREQ_W    = 16;
    localparam int ADDR_W    = 8;
    localparam int LEVEL_W   = 2;
    localparam int DUTY_W    = 5;

    localparam int DIV_W     = 26;
    localparam int DSR_W     = 16;
    localparam int STEP_W    = 5;

    localparam logic [STEP_W-1:0] PERIOD_STEPS  = STEP_W'(PERIOD_W);
    localparam logic [STEP_W-1:0] COMPARE_STEPS = STEP_W'(DIV_W);
    localparam logic [DIV_W-1:0]  PERIOD_DIVIDEND =
        DIV_W'(TIMER_CLOCK_HZ) << (DIV_W - PERIOD_W);
    localparam logic [DSR_W-1:0]  DUTY_DIVISOR = DSR_W'(DUTY_SCALE);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PLAY = 1'b1;

    localparam logic [LEVEL_W-1:0] LEVEL_MUTE  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 2'd3;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [31:0] pr(input logic [15:0] f, input logic [15:0] d);
        return {f, d};
    endfunction

    function automatic logic [31:0] note_pair(input logic [ADDR_W-1:0] a);
        logic [31:0] r;
        case (a)
            8'd0:   r = pr(16'd0, 16'd80);
            8'd1:   r = pr(16'd0, 16'd0);
            8'd2:   r = pr(16'd2332, 16'd80);
            8'd3:   r = pr(16'd2512, 16'd80);
            8'd4:   r = pr(16'd2839, 16'd80);
            8'd5:   r = pr(16'd0, 16'd80);
            8'd6:   r = pr(16'd0, 16'd0);
            8'd7:   r = pr(16'd2968, 16'd80);
            8'd8:   r = pr(16'd3265, 16'd80);
            8'd9:   r = pr(16'd0, 16'd80);
            8'd10:  r = pr(16'd0, 16'd0);
            8'd11:  r = pr(16'd717, 16'd80);
            8'd12:  r = pr(16'd0, 16'd80);
            8'd13:  r = pr(16'd717, 16'd80);
            8'd14:  r = pr(16'd0, 16'd80);
            8'd15:  r = pr(16'd0, 16'd0);
            8'd16:  r = pr(16'd2176, 16'd1000);
            8'd17:  r = pr(16'd0, 16'd80);
            8'd18:  r = pr(16'd0, 16'd0);
            8'd19:  r = pr(16'd2176, 16'd80);
            8'd20:  r = pr(16'd0, 16'd80);
            8'd21:  r = pr(16'd2176, 16'd80);
            8'd22:  r = pr(16'd0, 16'd80);
            8'd23:  r = pr(16'd0, 16'd0);
            8'd24:  r = pr(16'd2176, 16'd80);
            8'd25:  r = pr(16'd0, 16'd80);
            8'd26:  r = pr(16'd0, 16'd0);
            8'd27:  r = pr(16'd742, 16'd80);
            8'd28:  r = pr(16'd0, 16'd80);
            8'd29:  r = pr(16'd0, 16'd0);
            8'd30:  r = pr(16'd1070, 16'd200);
            8'd31:  r = pr(16'd1209, 16'd200);
            8'd32:  r = pr(16'd0, 16'd40);
            8'd33:  r = pr(16'd0, 16'd0);
            8'd34:  r = pr(16'd784, 16'd125);
            8'd35:  r = pr(16'd0, 16'd40);
            8'd36:  r = pr(16'd784, 16'd125);
            8'd37:  r = pr(16'd0, 16'd40);
            8'd38:  r = pr(16'd784, 16'd125);
            8'd39:  r = pr(16'd0, 16'd40);
            8'd40:  r = pr(16'd1046, 16'd437);
            8'd41:  r = pr(16'd0, 16'd40);
            8'd42:  r = pr(16'd1318, 16'd250);
            8'd43:  r = pr(16'd0, 16'd80);
            8'd44:  r = pr(16'd0, 16'd0);
            8'd45:  r = pr(16'd0, 16'd250);
            8'd46:  r = pr(16'd1046, 16'd250);
            8'd47:  r = pr(16'd0, 16'd40);
            8'd48:  r = pr(16'd1046, 16'd125);
            8'd49:  r = pr(16'd0, 16'd40);
            8'd50:  r = pr(16'd988, 16'd125);
            8'd51:  r = pr(16'd0, 16'd40);
            8'd52:  r = pr(16'd988, 16'd125);
            8'd53:  r = pr(16'd0, 16'd40);
            8'd54:  r = pr(16'd880, 16'd125);
            8'd55:  r = pr(16'd0, 16'd40);
            8'd56:  r = pr(16'd880, 16'd125);
            8'd57:  r = pr(16'd0, 16'd40);
            8'd58:  r = pr(16'd784, 16'd250);
            8'd59:  r = pr(16'd0, 16'd40);
            8'd60:  r = pr(16'd0, 16'd0);
            8'd61:  r = pr(16'd784, 16'd125);
            8'd62:  r = pr(16'd0, 16'd40);
            8'd63:  r = pr(16'd784, 16'd125);
            8'd64:  r = pr(16'd0, 16'd40);
            8'd65:  r = pr(16'd784, 16'd125);
            8'd66:  r = pr(16'd0, 16'd40);
            8'd67:  r = pr(16'd988, 16'd437);
            8'd68:  r = pr(16'd0, 16'd40);
            8'd69:  r = pr(16'd1175, 16'd250);
            8'd70:  r = pr(16'd0, 16'd80);
            8'd71:  r = pr(16'd0, 16'd0);
            8'd72:  r = pr(16'd0, 16'd250);
            8'd73:  r = pr(16'd784, 16'd250);
            8'd74:  r = pr(16'd0, 16'd40);
            8'd75:  r = pr(16'd784, 16'd125);
            8'd76:  r = pr(16'd0, 16'd40);
            8'd77:  r = pr(16'd880, 16'd125);
            8'd78:  r = pr(16'd0, 16'd40);
            8'd79:  r = pr(16'd880, 16'd125);
            8'd80:  r = pr(16'd0, 16'd40);
            8'd81:  r = pr(16'd988, 16'd125);
            8'd82:  r = pr(16'd0, 16'd40);
            8'd83:  r = pr(16'd988, 16'd125);
            8'd84:  r = pr(16'd0, 16'd40);
            8'd85:  r = pr(16'd1046, 16'd250);
            8'd86:  r = pr(16'd0, 16'd40);
            8'd87:  r = pr(16'd0, 16'd0);
            8'd88:  r = pr(16'd523, 16'd500);
            8'd89:  r = pr(16'd80, 16'd0);
            8'd90:  r = pr(16'd656, 16'd250);
            8'd91:  r = pr(16'd80, 16'd0);
            8'd92:  r = pr(16'd784, 16'd250);
            8'd93:  r = pr(16'd80, 16'd0);
            8'd94:  r = pr(16'd1047, 16'd125);
            8'd95:  r = pr(16'd80, 16'd0);
            8'd96:  r = pr(16'd1047, 16'd125);
            8'd97:  r = pr(16'd80, 16'd0);
            8'd98:  r = pr(16'd1047, 16'd125);
            8'd99:  r = pr(16'd80, 16'd0);
            8'd100: r = pr(16'd1047, 16'd125);
            8'd101: r = pr(16'd80, 16'd0);
            8'd102: r = pr(16'd1047, 16'd125);
            8'd103: r = pr(16'd80, 16'd0);
            8'd104: r = pr(16'd1047, 16'd125);
            8'd105: r = pr(16'd80, 16'd0);
            8'd106: r = pr(16'd988, 16'd125);
            8'd107: r = pr(16'd1047, 16'd125);
            8'd108: r = pr(16'd1175, 16'd125);
            8'd109: r = pr(16'd80, 16'd0);
            8'd110: r = pr(16'd1175, 16'd125);
            8'd111: r = pr(16'd80, 16'd0);
            8'd112: r = pr(16'd1175, 16'd125);
            8'd113: r = pr(16'd80, 16'd0);
            8'd114: r = pr(16'd1175, 16'd125);
            8'd115: r = pr(16'd80, 16'd0);
            8'd116: r = pr(16'd1175, 16'd125);
            8'd117: r = pr(16'd80, 16'd0);
            8'd118: r = pr(16'd1175, 16'd125);
            8'd119: r = pr(16'd80, 16'd0);
            8'd120: r = pr(16'd1047, 16'd125);
            8'd121: r = pr(16'd1175, 16'd125);
            8'd122: r = pr(16'd1319, 16'd500);
            8'd123: r = pr(16'd1175, 16'd500);
            8'd124: r = pr(16'd1047, 16'd250);
            8'd125: r = pr(16'd784, 16'd250);
            8'd126: r = pr(16'd1047, 16'd250);
            8'd127: r = pr(16'd0, 16'd80);
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] melody_start(input logic [MEL_W-1:0] m);
        logic [ADDR_W-1:0] r;
        case (m)
            4'd0:    r = 8'd0;
            4'd1:    r = 8'd2;
            4'd2:    r = 8'd7;
            4'd3:    r = 8'd11;
            4'd4:    r = 8'd16;
            4'd5:    r = 8'd19;
            4'd6:    r = 8'd24;
            4'd7:    r = 8'd27;
            4'd8:    r = 8'd30;
            4'd9:    r = 8'd34;
            4'd10:   r = 8'd45;
            4'd11:   r = 8'd61;
            4'd12:   r = 8'd72;
            4'd13:   r = 8'd88;
            default: r = 8'd0;
        endcase
        if (32'(m) >= MELODY_COUNT) begin
            r = 8'd0;
        end
        return r;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] lvl);
        logic [DUTY_W-1:0] r;
        case (lvl)
            2'd1:    r = 5'd1;
            2'd2:    r = 5'd5;
            2'd3:    r = 5'd20;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/pwm_melody_sequencer_unit.sv
// Top level of the PWM melody sequencer: request decode, note control, output register.
`timescale 1ns / 1ps

// The slave channel takes one request at a time: s_tuser[0] is the opcode
// (0 a one millisecond tick, 1 a play request) and s_tdata[3:0] the melody
// number. Every request yields exactly one result on the master channel,
// which carries the PWM settings, the note-start flag, the pending count
// and the queue-accept flag. The volume level is written through cfg_wr_en
// and cfg_wr_data; the user is to write it only while the block is idle,
// which the block itself does not enforce; level 0 mutes.
// A play request or a tick that loads no tone goes from S_IDLE to S_OUT,
// which loads the output register once out_free is set. A tick that loads
// a tone runs two passes through the serial divider, S_DIV_PER for the
// period and S_DIV_CMP for the compare value, with S_MUL between them,
// before S_OUT loads its result into the output register.
// The next request is taken as soon as the control returns to idle, even
// while the previous result still waits in the output register; a stalled
// receiver holds one finished result and then blocks the slave channel.
// Reset clears the queue, the note position and the PWM values and sets
// the volume level to 3.
module pwm_melody_sequencer_unit #(
    parameter int QUEUE_DEPTH = pms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // melody_number[3:0], zero padding
    input  logic [0:0]  s_tuser,      // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // tone_on[0], period_ticks[21:1], compare_ticks[39:22], note_started[40],
    // pending_count[43:41], request_accepted[44], zero padding
    output logic [47:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data
);
    import pms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_DIV_PER = 5'b00010,
        S_MUL     = 5'b00100,
        S_DIV_CMP = 5'b01000,
        S_OUT     = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [MS_W-1:0]      remaining_reg, remaining_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [ADDR_W-1:0]    offset_reg, offset_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [COMPARE_W-1:0] compare_reg, compare_next;
    logic                 started_reg, started_next;
    logic                 accepted_reg, accepted_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [47:0]          m_tdata_reg, m_tdata_next;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic                 q_push;
    logic                 q_pop;
    logic [MEL_W-1:0]     q_head;
    logic                 q_not_empty;
    logic [PEND_W-1:0]    q_pending;

    logic                 s_fire;
    logic                 opcode;
    logic [MEL_W-1:0]     melody_number;
    logic [MS_W-1:0]      rem_dec;
    logic [31:0]          pair;
    logic [FREQ_W-1:0]    freq;
    logic [MS_W-1:0]      dur;
    logic [DIV_W-1:0]     product;
    logic                 out_free;

    assign s_tready      = state_reg == S_IDLE;
    assign s_fire        = s_tvalid && s_tready;
    assign opcode        = s_tuser[0];
    assign melody_number = s_tdata[MEL_W-1:0];
    assign rem_dec       = (remaining_reg != '0) ? remaining_reg - 1'b1 : '0;
    assign pair          = note_pair(base_reg + offset_reg);
    assign freq          = pair[31:16];
    assign dur           = pair[15:0];
    assign product       = DIV_W'(period_reg) * DIV_W'(duty_of(level_reg));
    assign out_free      = !m_tvalid_reg || m_tready;

    pms_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (melody_number),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .pending   (q_pending)
    );

    pms_serial_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        remaining_next = remaining_reg;
        base_next      = base_reg;
        offset_next    = offset_reg;
        period_next    = period_reg;
        compare_next   = compare_reg;
        started_next   = started_reg;
        accepted_next  = accepted_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        div_req        = '0;
        q_push         = 1'b0;
        q_pop          = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    started_next  = 1'b0;
                    accepted_next = 1'b0;
                    state_next    = S_OUT;
                    if (opcode == OP_PLAY) begin
                        if (level_reg != LEVEL_MUTE) begin
                            q_push        = 1'b1;
                            accepted_next = 1'b1;
                        end
                    end else begin
                        remaining_next = rem_dec;
                        if (rem_dec == '0 && level_reg != LEVEL_MUTE) begin
                            if (freq == '0 && dur == '0) begin
                                if (q_not_empty) begin
                                    q_pop       = 1'b1;
                                    base_next   = melody_start(q_head);
                                    offset_next = '0;
                                end
                            end else begin
                                remaining_next = dur;
                                offset_next    = offset_reg + 1'b1;
                                started_next   = 1'b1;
                                if (freq == '0) begin
                                    compare_next = '0;
                                end else begin
                                    div_req.start    = 1'b1;
                                    div_req.steps    = PERIOD_STEPS;
                                    div_req.dividend = PERIOD_DIVIDEND;
                                    div_req.divisor  = freq;
                                    state_next       = S_DIV_PER;
                                end
                            end
                        end
                    end
                end
            end
            S_DIV_PER: begin
                if (div_rsp.done) begin
                    period_next = div_rsp.quotient[PERIOD_W-1:0];
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                div_req.start    = 1'b1;
                div_req.steps    = COMPARE_STEPS;
                div_req.dividend = product;
                div_req.divisor  = DUTY_DIVISOR;
                state_next       = S_DIV_CMP;
            end
            S_DIV_CMP: begin
                if (div_rsp.done) begin
                    compare_next = div_rsp.quotient[COMPARE_W-1:0];
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, accepted_reg, q_pending, started_reg,
                                     compare_reg, period_reg, compare_reg != '0};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            level_next = cfg_wr_data;
            if (cfg_wr_data == LEVEL_MUTE) begin
                compare_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            level_reg     <= LEVEL_RESET;
            remaining_reg <= '0;
            base_reg      <= '0;
            offset_reg    <= '0;
            period_reg    <= '0;
            compare_reg   <= '0;
            started_reg   <= 1'b0;
            accepted_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            remaining_reg <= remaining_next;
            base_reg      <= base_next;
            offset_reg    <= offset_next;
            period_reg    <= period_next;
            compare_reg   <= compare_next;
            started_reg   <= started_next;
            accepted_reg  <= accepted_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_mute_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg == LEVEL_MUTE |-> compare_reg == '0)
        else $error("compare value nonzero while muted");
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV_PER || state_reg == S_DIV_CMP))
        else $error("divider result outside a divide state");
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free) |=> (m_tvalid_reg && state_reg == S_IDLE))
        else $error("result not loaded into the output register");
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[40] && m_tdata_reg[44]))
        else $error("note start and request accept in one result");
`endif

endmodule

FILE: rtl/pms_serial_div.sv
// Bit-serial restoring divider, one quotient bit per clock cycle.
`timescale 1ns / 1ps

module pms_serial_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  pms_pkg::div_req_t req,
    output pms_pkg::div_rsp_t rsp
);
    import pms_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DSR_W:0]    trial;
    logic [DSR_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            rem_next = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");
`endif

endmodule

FILE: rtl/pms_queue.sv
// Ring of queued melody numbers with wrapping pending count.
`timescale 1ns / 1ps

module pms_queue #(
    parameter int DEPTH = pms_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  logic [pms_pkg::MEL_W-1:0]  push_data,
    input  logic                       pop,
    output logic [pms_pkg::MEL_W-1:0]  head,
    output logic                       not_empty,
    output logic [pms_pkg::PEND_W-1:0] pending
);
    import pms_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_C  = (PTR_W + 1)'(DEPTH);

    logic [MEL_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   pend_full;
    logic [PTR_W+PEND_W-1:0] pend_ext;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                entry_reg[i] <= '0;
            end
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            if (push) begin
                entry_reg[wr_ptr_reg] <= push_data;
            end
        end
    end

    assign pend_full = (wr_ptr_reg >= rd_ptr_reg)
                     ? {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg}
                     : {1'b0, wr_ptr_reg} + DEPTH_C - {1'b0, rd_ptr_reg};
    assign pend_ext  = {{(PEND_W - 1){1'b0}}, pend_full};
    assign pending   = pend_ext[PEND_W-1:0];
    assign not_empty = wr_ptr_reg != rd_ptr_reg;
    assign head      = entry_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue popped while empty");
    a_push_pop_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && pop))
        else $error("queue push and pop in the same cycle");
    a_pop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> rd_ptr_reg != $past(rd_ptr_reg))
        else $error("queue read pointer did not advance");
`endif

endmodule

FILE: test/melody_result_checker.sv
// Checker that predicts each PWM result of the melody sequencer and compares it field by field.
`timescale 1ns / 1ps

module melody_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,      // melody_number[3:0], zero padding
    input  logic [0:0]  s_tuser,      // opcode[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    // tone_on[0], period_ticks[21:1], compare_ticks[39:22], note_started[40],
    // pending_count[43:41], request_accepted[44], zero padding
    input  logic [47:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    output int          mismatches,
    output int          results_due,
    output int          instant_notes
);
    import pms_pkg::*;

    localparam int NOTE_PAIRS = 129;

    typedef struct packed {
        logic                 request_accepted;
        logic [PEND_W-1:0]    pending_count;
        logic                 note_started;
        logic [COMPARE_W-1:0] compare_ticks;
        logic [PERIOD_W-1:0]  period_ticks;
        logic                 tone_on;
    } pwm_result_t;

    int unsigned note_hz [NOTE_PAIRS] = '{
        0, 0, 2332, 2512, 2839, 0, 0, 2968, 3265, 0, 0,
        717, 0, 717, 0, 0, 2176, 0, 0, 2176, 0, 2176, 0, 0,
        2176, 0, 0, 742, 0, 0, 1070, 1209, 0, 0,
        784, 0, 784, 0, 784, 0, 1046, 0, 1318, 0, 0,
        0, 1046, 0, 1046, 0, 988, 0, 988, 0, 880, 0, 880, 0, 784, 0, 0,
        784, 0, 784, 0, 784, 0, 988, 0, 1175, 0, 0,
        0, 784, 0, 784, 0, 880, 0, 880, 0, 988, 0, 988, 0, 1046, 0, 0,
        523, 80, 656, 80, 784, 80, 1047, 80, 1047, 80, 1047, 80,
        1047, 80, 1047, 80, 1047, 80, 988, 1047,
        1175, 80, 1175, 80, 1175, 80, 1175, 80, 1175, 80, 1175, 80,
        1047, 1175, 1319, 1175, 1047, 784, 1047, 0, 0
    };

    int unsigned note_ms [NOTE_PAIRS] = '{
        80, 0, 80, 80, 80, 80, 0, 80, 80, 80, 0,
        80, 80, 80, 80, 0, 1000, 80, 0, 80, 80, 80, 80, 0,
        80, 80, 0, 80, 80, 0, 200, 200, 40, 0,
        125, 40, 125, 40, 125, 40, 437, 40, 250, 80, 0,
        250, 250, 40, 125, 40, 125, 40, 125, 40, 125, 40, 125, 40, 250, 40, 0,
        125, 40, 125, 40, 125, 40, 437, 40, 250, 80, 0,
        250, 250, 40, 125, 40, 125, 40, 125, 40, 125, 40, 125, 40, 250, 40, 0,
        500, 0, 250, 0, 250, 0, 125, 0, 125, 0, 125, 0,
        125, 0, 125, 0, 125, 0, 125, 125,
        125, 0, 125, 0, 125, 0, 125, 0, 125, 0, 125, 0,
        125, 125, 500, 500, 250, 250, 250, 80, 0
    };

    logic [ADDR_W-1:0] melody_entry [16] = '{
        8'd0, 8'd2, 8'd7, 8'd11, 8'd16, 8'd19, 8'd24, 8'd27,
        8'd30, 8'd34, 8'd45, 8'd61, 8'd72, 8'd88, 8'd0, 8'd0
    };

    int unsigned duty_by_level [4] = '{0, 1, 5, 20};

    logic [LEVEL_W-1:0]   level;
    logic [MEL_W-1:0]     ring [QUEUE_DEPTH_DEF];
    logic [PEND_W-1:0]    wr_ptr;
    logic [PEND_W-1:0]    rd_ptr;
    logic [MS_W-1:0]      ms_left;
    logic [ADDR_W-1:0]    base;
    logic [ADDR_W-1:0]    offset;
    logic [PERIOD_W-1:0]  period;
    logic [COMPARE_W-1:0] compare;
    pwm_result_t          settings_due [$];

    function automatic pwm_result_t advance_melody(input logic op, input logic [MEL_W-1:0] mel);
        pwm_result_t       r;
        logic [ADDR_W-1:0] addr;
        int unsigned       hz;
        int unsigned       ms;
        logic [MEL_W-1:0]  next_mel;
        r = '0;
        if (op == OP_TICK) begin
            if (ms_left != 0) begin
                ms_left = ms_left - 1'b1;
            end
            if (ms_left == 0 && level != LEVEL_MUTE) begin
                addr = base + offset;
                hz = (addr < NOTE_PAIRS) ? note_hz[addr] : 0;
                ms = (addr < NOTE_PAIRS) ? note_ms[addr] : 0;
                if (hz == 0 && ms == 0) begin
                    if (wr_ptr != rd_ptr) begin
                        next_mel = ring[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        base = (next_mel < MELODY_COUNT) ? melody_entry[next_mel] : '0;
                        offset = '0;
                    end
                end else begin
                    compare = '0;
                    if (hz != 0) begin
                        period = PERIOD_W'(TIMER_CLOCK_HZ / hz);
                        compare = COMPARE_W'((32'(period) * duty_by_level[level])
                                             / DUTY_SCALE);
                    end
                    ms_left = MS_W'(ms);
                    offset = offset + 1'b1;
                    r.note_started = 1'b1;
                    if (ms == 0) begin
                        instant_notes++;
                    end
                end
            end
        end else if (level != LEVEL_MUTE) begin
            ring[wr_ptr] = mel;
            wr_ptr = wr_ptr + 1'b1;
            r.request_accepted = 1'b1;
        end
        r.tone_on = (compare != 0);
        r.period_ticks = period;
        r.compare_ticks = compare;
        r.pending_count = wr_ptr - rd_ptr;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin : watch
        pwm_result_t got;
        pwm_result_t want;
        if (!aresetn) begin
            level = LEVEL_RESET;
            foreach (ring[i]) begin
                ring[i] = '0;
            end
            wr_ptr = '0;
            rd_ptr = '0;
            ms_left = '0;
            base = '0;
            offset = '0;
            period = '0;
            compare = '0;
            settings_due.delete();
            mismatches = 0;
            instant_notes = 0;
        end else begin
            if (cfg_wr_en) begin
                level = cfg_wr_data;
                if (level == LEVEL_MUTE) begin
                    compare = '0;
                end
            end
            if (s_tvalid && s_tready) begin
                settings_due.push_back(advance_melody(s_tuser[0], s_tdata[MEL_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                got = pwm_result_t'(m_tdata[$bits(pwm_result_t)-1:0]);
                if (settings_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result %h arrived with no request pending",
                                 $time, m_tdata);
                    end
                end else begin
                    want = settings_due.pop_front();
                    check_field("tone_on", want.tone_on, got.tone_on);
                    check_field("period_ticks", want.period_ticks, got.period_ticks);
                    check_field("compare_ticks", want.compare_ticks, got.compare_ticks);
                    check_field("note_started", want.note_started, got.note_started);
                    check_field("pending_count", want.pending_count, got.pending_count);
                    check_field("request_accepted", want.request_accepted,
                                got.request_accepted);
                end
            end
        end
        results_due = settings_due.size();
    end

endmodule

FILE: test/tb_pwm_melody_sequencer_unit.sv
// Testbench top for the melody sequencer: clock, reset, request and volume stimulus, verdict.
`timescale 1ns / 1ps

module tb_pwm_melody_sequencer_unit;
    import pms_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic [0:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_wr_data = '0;

    int mismatches;
    int results_due;
    int instant_notes;
    int cycle_count   = 0;
    bit sender_steady = 1'b0;

    logic [MEL_W-1:0] brief_melodies [8] = '{
        4'd0, 4'd1, 4'd2, 4'd5, 4'd6, 4'd7, 4'd14, 4'd15
    };

    pwm_melody_sequencer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    melody_result_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatches     (mismatches),
        .results_due    (results_due),
        .instant_notes  (instant_notes)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [MEL_W-1:0] mel);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, mel};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (results_due != 0) @(negedge aclk);
    endtask

    task automatic set_level(input logic [LEVEL_W-1:0] lvl);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lvl;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // The receiver stalls on its own schedule, including one long hold-off
    // every 700 results so that the block backs up into its input.
    initial begin : result_sink
        int gap;
        int taken;
        bit steady;
        gap = 0;
        taken = 0;
        steady = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_tready <= (gap == 0);
            if (gap > 0) begin
                gap--;
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                taken++;
                if (taken % 100 == 0) begin
                    steady = ($urandom_range(0, 2) == 0);
                end
                if (taken % 700 == 150) begin
                    gap = LONG_HOLD;
                end else begin
                    gap = steady ? 0 : $urandom_range(0, 6);
                end
            end
        end
    end

    initial begin : stimulus
        int items;
        int phase_len;
        int burst;
        int pick;
        logic [LEVEL_W-1:0] lvl;
        logic [MEL_W-1:0] mel;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The first tick loads the pause of the silent melody; nine requests
        // then wrap the queue, so only the last one stays pending and the long
        // melody queued third is lost.
        send_request(OP_TICK, 4'd0);
        send_request(OP_PLAY, 4'd0);
        send_request(OP_PLAY, 4'd15);
        send_request(OP_PLAY, 4'd13);
        send_request(OP_PLAY, 4'd8);
        send_request(OP_PLAY, 4'd1);
        send_request(OP_PLAY, 4'd2);
        send_request(OP_PLAY, 4'd4);
        send_request(OP_PLAY, 4'd14);
        send_request(OP_PLAY, 4'd5);
        set_level(LEVEL_MUTE);
        send_request(OP_PLAY, 4'd7);
        send_request(OP_TICK, 4'd15);
        send_request(OP_TICK, 4'd0);
        set_level(2'd1);
        send_request(OP_TICK, 4'd9);
        send_request(OP_PLAY, 4'd6);

        items = 0;
        while (items < RANDOM_ITEMS) begin
            lvl = ($urandom_range(0, 7) == 0) ? LEVEL_MUTE : LEVEL_W'($urandom_range(1, 3));
            set_level(lvl);
            sender_steady = ($urandom_range(0, 3) == 0);
            phase_len = (lvl == LEVEL_MUTE) ? $urandom_range(10, 40) : $urandom_range(60, 300);
            for (int k = 0; k < phase_len && items < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    burst = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 11) : 1;
                    repeat (burst) begin
                        pick = $urandom_range(0, 99);
                        if ((items >= RANDOM_ITEMS / 2 && instant_notes == 0) || pick < 3) begin
                            mel = 4'd13;
                        end else if (pick < 20) begin
                            mel = MEL_W'($urandom);
                        end else begin
                            mel = brief_melodies[$urandom_range(0, 7)];
                        end
                        send_request(OP_PLAY, mel);
                        items++;
                    end
                end else begin
                    send_request(OP_TICK, MEL_W'($urandom));
                    items++;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: pwm_melody_sequencer_unit.f
rtl/pms_pkg.sv
rtl/pms_serial_div.sv
rtl/pms_queue.sv
rtl/pwm_melody_sequencer_unit.sv
test/melody_result_checker.sv
test/tb_pwm_melody_sequencer_unit.sv
